### hdl/sudiv_pkg.sv
// ----------------------------------------------------------------------------
// sudiv_pkg: shared definitions for the signed/unsigned divider
// Port width, default operand width, opcodes and per-request control flags.
// ----------------------------------------------------------------------------
package sudiv_pkg;

  localparam int PORT_W         = 64;
  localparam int DATA_WIDTH_DEF = 64;
  localparam int OP_W           = 2;

  localparam logic [OP_W-1:0] OP_UQUO = 2'd0;
  localparam logic [OP_W-1:0] OP_UREM = 2'd1;
  localparam logic [OP_W-1:0] OP_SQUO = 2'd2;
  localparam logic [OP_W-1:0] OP_SREM = 2'd3;

  typedef struct packed {
    logic sel_rem;   // deliver remainder instead of quotient
    logic neg_quo;   // operand signs differ on a signed request
    logic neg_rem;   // negative dividend on a signed request
  } ctrl_t;

endpackage

### hdl/sudiv_prep.sv
// ----------------------------------------------------------------------------
// sudiv_prep: operand conditioning stage
// Decodes the opcode, takes operand magnitudes and registers the request.
// ----------------------------------------------------------------------------
module sudiv_prep #(
  parameter int DATA_WIDTH = sudiv_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  logic [sudiv_pkg::OP_W-1:0]        up_opcode,
  input  logic [sudiv_pkg::PORT_W-1:0]      up_dividend,
  input  logic [sudiv_pkg::PORT_W-1:0]      up_divisor,
  output logic                              dn_valid,
  input  logic                              dn_ready,
  output sudiv_pkg::ctrl_t                  dn_ctrl,
  output logic [DATA_WIDTH-1:0]             dn_num,
  output logic [DATA_WIDTH-1:0]             dn_den
);

  logic                  valid_r;
  sudiv_pkg::ctrl_t      ctrl_r, ctrl_nxt;
  logic [DATA_WIDTH-1:0] num_r, num_nxt;
  logic [DATA_WIDTH-1:0] den_r, den_nxt;
  logic [DATA_WIDTH-1:0] num_raw, den_raw;
  logic                  is_signed, num_neg, den_neg;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    num_raw   = up_dividend[DATA_WIDTH-1:0];
    den_raw   = up_divisor[DATA_WIDTH-1:0];
    is_signed = (up_opcode == sudiv_pkg::OP_SQUO) || (up_opcode == sudiv_pkg::OP_SREM);
    num_neg   = is_signed && num_raw[DATA_WIDTH-1];
    den_neg   = is_signed && den_raw[DATA_WIDTH-1];
    num_nxt   = num_neg ? (~num_raw + DATA_WIDTH'(1)) : num_raw;
    den_nxt   = den_neg ? (~den_raw + DATA_WIDTH'(1)) : den_raw;
    ctrl_nxt.sel_rem = (up_opcode == sudiv_pkg::OP_UREM) || (up_opcode == sudiv_pkg::OP_SREM);
    ctrl_nxt.neg_quo = num_neg ^ den_neg;
    ctrl_nxt.neg_rem = num_neg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      ctrl_r <= ctrl_nxt;
      num_r  <= num_nxt;
      den_r  <= den_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_ctrl  = ctrl_r;
  assign dn_num   = num_r;
  assign dn_den   = den_r;

endmodule

### hdl/sudiv_cell.sv
// ----------------------------------------------------------------------------
// sudiv_cell: one restoring division step
// Shifts in one dividend bit, trial-subtracts the divisor and registers the
// partial remainder together with the combined dividend/quotient word.
// ----------------------------------------------------------------------------
module sudiv_cell #(
  parameter int DATA_WIDTH = sudiv_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  sudiv_pkg::ctrl_t      up_ctrl,
  input  logic [DATA_WIDTH-1:0] up_rem,
  input  logic [DATA_WIDTH-1:0] up_nq,
  input  logic [DATA_WIDTH-1:0] up_den,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output sudiv_pkg::ctrl_t      dn_ctrl,
  output logic [DATA_WIDTH-1:0] dn_rem,
  output logic [DATA_WIDTH-1:0] dn_nq,
  output logic [DATA_WIDTH-1:0] dn_den
);

  logic                  valid_r;
  sudiv_pkg::ctrl_t      ctrl_r;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] nq_r, nq_nxt;
  logic [DATA_WIDTH-1:0] den_r;
  logic [DATA_WIDTH:0]   part, diff;

  assign up_ready = !valid_r || dn_ready;

  // nq holds the unused dividend bits on top and grows quotient bits below
  always_comb begin
    part    = {up_rem, up_nq[DATA_WIDTH-1]};
    diff    = part - {1'b0, up_den};
    rem_nxt = diff[DATA_WIDTH] ? part[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
    nq_nxt  = {up_nq[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      ctrl_r <= up_ctrl;
      rem_r  <= rem_nxt;
      nq_r   <= nq_nxt;
      den_r  <= up_den;
    end
  end

  assign dn_valid = valid_r;
  assign dn_ctrl  = ctrl_r;
  assign dn_rem   = rem_r;
  assign dn_nq    = nq_r;
  assign dn_den   = den_r;

endmodule

### hdl/sudiv_post.sv
// ----------------------------------------------------------------------------
// sudiv_post: sign fix-up and output register
// Selects quotient or remainder, applies the result sign, holds the result.
// ----------------------------------------------------------------------------
module sudiv_post #(
  parameter int DATA_WIDTH = sudiv_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  sudiv_pkg::ctrl_t             up_ctrl,
  input  logic [DATA_WIDTH-1:0]        up_rem,
  input  logic [DATA_WIDTH-1:0]        up_quo,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output logic [sudiv_pkg::PORT_W-1:0] dn_result
);

  localparam int PW = sudiv_pkg::PORT_W;

  logic                  valid_r;
  logic [PW-1:0]         result_r, result_nxt;
  logic [DATA_WIDTH-1:0] mag;
  logic                  neg;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    mag        = up_ctrl.sel_rem ? up_rem : up_quo;
    neg        = up_ctrl.sel_rem ? up_ctrl.neg_rem : up_ctrl.neg_quo;
    result_nxt = PW'(neg ? (~mag + DATA_WIDTH'(1)) : mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      result_r <= result_nxt;
    end
  end

  assign dn_valid  = valid_r;
  assign dn_result = result_r;

endmodule

### hdl/signed_unsigned_divider_64_core.sv
// ----------------------------------------------------------------------------
// signed_unsigned_divider_64_core: pipelined restoring divider
// Pipeline: one operand stage, one cell per quotient bit, one sign/output stage.
// Throughput one request per cycle while out_ready is high; each stage stalls
// only when full and blocked downstream, so bubbles are squeezed out.
// Synchronous active-low reset clears the stage valid flags only.
// ----------------------------------------------------------------------------
module signed_unsigned_divider_64_core #(
  parameter int DATA_WIDTH = sudiv_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [sudiv_pkg::OP_W-1:0]   in_opcode,
  input  logic [sudiv_pkg::PORT_W-1:0] in_dividend,
  input  logic [sudiv_pkg::PORT_W-1:0] in_divisor,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sudiv_pkg::PORT_W-1:0] out_result
);

  logic                  vld [DATA_WIDTH+1];
  logic                  rdy [DATA_WIDTH+1];
  sudiv_pkg::ctrl_t      ctl [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] rem [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] nq  [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] den [DATA_WIDTH+1];

  assign rem[0] = '0;

  sudiv_prep #(.DATA_WIDTH(DATA_WIDTH)) u_prep (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (in_valid),
    .up_ready    (in_ready),
    .up_opcode   (in_opcode),
    .up_dividend (in_dividend),
    .up_divisor  (in_divisor),
    .dn_valid    (vld[0]),
    .dn_ready    (rdy[0]),
    .dn_ctrl     (ctl[0]),
    .dn_num      (nq[0]),
    .dn_den      (den[0])
  );

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
    sudiv_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld[i]),
      .up_ready (rdy[i]),
      .up_ctrl  (ctl[i]),
      .up_rem   (rem[i]),
      .up_nq    (nq[i]),
      .up_den   (den[i]),
      .dn_valid (vld[i+1]),
      .dn_ready (rdy[i+1]),
      .dn_ctrl  (ctl[i+1]),
      .dn_rem   (rem[i+1]),
      .dn_nq    (nq[i+1]),
      .dn_den   (den[i+1])
    );
  end

  sudiv_post #(.DATA_WIDTH(DATA_WIDTH)) u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (vld[DATA_WIDTH]),
    .up_ready  (rdy[DATA_WIDTH]),
    .up_ctrl   (ctl[DATA_WIDTH]),
    .up_rem    (rem[DATA_WIDTH]),
    .up_quo    (nq[DATA_WIDTH]),
    .dn_valid  (out_valid),
    .dn_ready  (out_ready),
    .dn_result (out_result)
  );

endmodule
